// ----- sv/time_zone_designator_parser_macros.svh -----
// Assertion macros shared by the time-zone designator parser.
`ifndef TIME_ZONE_DESIGNATOR_PARSER_MACROS_SVH
`define TIME_ZONE_DESIGNATOR_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TZD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tzd_pkg.sv -----
// Types, constants and zone table for the time-zone designator parser.
`timescale 1ns / 1ps
`default_nettype none

package tzd_pkg;

  localparam int unsigned NumZones = 34;
  localparam logic [18:0] SecsPerHour = 19'd3600;
  localparam logic [18:0] SecsPerMinute = 19'd60;

  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero = 8'h30;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_LETTERS,
    PH_HOURS,
    PH_MINUTES
  } tzd_phase_e;

  typedef struct packed {
    tzd_phase_e  phase;
    logic [31:0] letters;      // letter k in bits 8k+7..8k
    logic [2:0]  letter_count;
    logic        negative;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [1:0]  digit_count;
  } tzd_state_t;

  localparam tzd_state_t StateClear = '{
    phase:        PH_SKIP,
    letters:      32'h0,
    letter_count: 3'd0,
    negative:     1'b0,
    hours:        7'd0,
    minutes:      7'd0,
    digit_count:  2'd0
  };

  typedef struct packed {
    logic [31:0]        name;  // first letter in the low byte, zero padded
    logic signed [19:0] secs;
  } tzd_zone_t;

  localparam tzd_zone_t ZoneTable [NumZones] = '{
    '{32'h0000005A, 20'sd0},        // Z
    '{32'h00005455, 20'sd0},        // UT
    '{32'h00544D47, 20'sd0},        // GMT
    '{32'h00545342, 20'sd3600},     // BST
    '{32'h00545349, 20'sd3600},     // IST
    '{32'h00544557, 20'sd0},        // WET
    '{32'h54534557, 20'sd3600},     // WEST
    '{32'h00544543, 20'sd3600},     // CET
    '{32'h54534543, 20'sd7200},     // CEST
    '{32'h00544545, 20'sd7200},     // EET
    '{32'h54534545, 20'sd10800},    // EEST
    '{32'h004B534D, 20'sd10800},    // MSK
    '{32'h0044534D, 20'sd14400},    // MSD
    '{32'h0054534E, -20'sd12600},   // NST
    '{32'h0054444E, -20'sd9000},    // NDT
    '{32'h00545341, -20'sd14400},   // AST
    '{32'h00544441, -20'sd10800},   // ADT
    '{32'h00545345, -20'sd18000},   // EST
    '{32'h00544445, -20'sd14400},   // EDT
    '{32'h00545343, -20'sd21600},   // CST
    '{32'h00544443, -20'sd18000},   // CDT
    '{32'h0054534D, -20'sd25200},   // MST
    '{32'h0054444D, -20'sd21600},   // MDT
    '{32'h00545350, -20'sd28800},   // PST
    '{32'h00544450, -20'sd25200},   // PDT
    '{32'h54534B41, -20'sd32400},   // AKST
    '{32'h54444B41, -20'sd28800},   // AKDT
    '{32'h00545348, -20'sd36000},   // HST
    '{32'h54534541, 20'sd36000},    // AEST
    '{32'h54444541, 20'sd39600},    // AEDT
    '{32'h54534341, 20'sd34200},    // ACST
    '{32'h54444341, 20'sd37800},    // ACDT
    '{32'h54535741, 20'sd28800},    // AWST
    '{32'h54445741, 20'sd32400}     // AWDT
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Names are unique and bytes past the letter count are zero, so an OR of
  // the matching entries equals the first match; no match gives zero.
  function automatic logic signed [19:0] zone_secs(input logic [31:0] letters);
    logic signed [19:0] secs;
    secs = '0;
    for (int i = 0; i < NumZones; i++) begin
      if (ZoneTable[i].name == letters) begin
        secs = secs | ZoneTable[i].secs;
      end
    end
    return secs;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tzd_step.sv -----
// Per-character parse step: next state, end-of-parse and taken flags.
`timescale 1ns / 1ps
`default_nettype none

module tzd_step (
  input  tzd_pkg::tzd_state_t state_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output tzd_pkg::tzd_state_t upd_o,    // state after this character
  output tzd_pkg::tzd_state_t next_o,   // state for the following character
  output logic                fin_o,
  output logic                taken_o
);

  logic       sign;
  logic       digit;
  logic [3:0] dval;
  logic       done;
  logic [1:0] dc_inc;

  assign sign   = (ch_i == tzd_pkg::ChPlus) || (ch_i == tzd_pkg::ChMinus);
  assign digit  = tzd_pkg::is_digit(ch_i);
  assign dval   = 4'(ch_i - tzd_pkg::ChZero);
  assign dc_inc = state_i.digit_count + 2'd1;

  always_comb begin
    upd_o   = state_i;
    taken_o = 1'b0;
    done    = 1'b0;
    unique case (state_i.phase)
      tzd_pkg::PH_SKIP: begin
        if (tzd_pkg::is_space(ch_i)) begin
          taken_o = 1'b1;
        end else if (tzd_pkg::is_alpha(ch_i)) begin
          upd_o.letters      = {24'h0, ch_i};
          upd_o.letter_count = 3'd1;
          upd_o.phase        = tzd_pkg::PH_LETTERS;
          taken_o            = 1'b1;
        end else if (sign) begin
          upd_o.negative = (ch_i == tzd_pkg::ChMinus);
          upd_o.phase    = tzd_pkg::PH_HOURS;
          taken_o        = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      tzd_pkg::PH_LETTERS: begin
        if (tzd_pkg::is_alpha(ch_i) && !state_i.letter_count[2]) begin
          upd_o.letters = state_i.letters
                        | ({24'h0, ch_i} << {state_i.letter_count[1:0], 3'b000});
          upd_o.letter_count = state_i.letter_count + 3'd1;
          taken_o            = 1'b1;
        end else if (sign) begin
          upd_o.negative = (ch_i == tzd_pkg::ChMinus);
          upd_o.phase    = tzd_pkg::PH_HOURS;
          taken_o        = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      tzd_pkg::PH_HOURS: begin
        if (digit && (state_i.digit_count < 2'd2)) begin
          upd_o.hours       = 7'(state_i.hours * 7'd10 + {3'b000, dval});
          upd_o.digit_count = dc_inc;
          taken_o           = 1'b1;
        end else if (ch_i == tzd_pkg::ChColon) begin
          upd_o.phase       = tzd_pkg::PH_MINUTES;
          upd_o.digit_count = 2'd0;
          taken_o           = 1'b1;
        end else if (digit) begin
          // third digit with no colon: first minute digit
          upd_o.minutes     = {3'b000, dval};
          upd_o.digit_count = 2'd1;
          upd_o.phase       = tzd_pkg::PH_MINUTES;
          taken_o           = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      tzd_pkg::PH_MINUTES: begin
        if (digit) begin
          upd_o.minutes     = 7'(state_i.minutes * 7'd10 + {3'b000, dval});
          upd_o.digit_count = dc_inc;
          taken_o           = 1'b1;
          done              = (dc_inc >= 2'd2);
        end else begin
          done = 1'b1;
        end
      end
    endcase
  end

  assign fin_o  = done || last_i;
  assign next_o = fin_o ? tzd_pkg::StateClear : upd_o;

endmodule

`default_nettype wire

// ----- sv/tzd_offset.sv -----
// Zone name lookup plus signed hour/minute adjustment, in seconds.
`timescale 1ns / 1ps
`default_nettype none

module tzd_offset (
  input  tzd_pkg::tzd_state_t state_i,
  output logic signed [19:0]  tz_offset_o
);

  logic [18:0]        amount;
  logic signed [19:0] amount_s;
  logic signed [19:0] zone;

  assign amount = 19'({12'h000, state_i.hours} * tzd_pkg::SecsPerHour)
                + 19'({12'h000, state_i.minutes} * tzd_pkg::SecsPerMinute);
  assign amount_s = $signed({1'b0, amount});
  assign zone     = tzd_pkg::zone_secs(state_i.letters);

  assign tz_offset_o = zone + (state_i.negative ? -amount_s : amount_s);

endmodule

`default_nettype wire

// ----- sv/time_zone_designator_parser.sv -----
// Top level of the time-zone designator parser.
`timescale 1ns / 1ps
`default_nettype none
`include "time_zone_designator_parser_macros.svh"

// Parses an RFC 822 style zone field one character per request: whitespace,
// up to four letters matched against 34 zone names, then an optional signed
// hh[:]mm offset. A result (offset in seconds, and whether the ending
// character was consumed) leaves when a parse ends: on last_i, on a character
// that does not fit, or on the second minute digit. A character is held in the
// input register and is then stepped into the parse state and the result
// register; one character per cycle is sustained while the result is not
// stalled. in_stall_o rises only while a character waits behind a stalled
// result.
module time_zone_designator_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [19:0] tz_offset_o,
  output logic               char_taken_o
);

  logic                in_valid_q;
  logic [7:0]          ch_q;
  logic                last_q;
  tzd_pkg::tzd_state_t state_q;
  tzd_pkg::tzd_state_t upd;
  tzd_pkg::tzd_state_t state_d;
  logic                fin;
  logic                taken;
  logic signed [19:0]  offset_d;
  logic                out_free;
  logic                adv;
  logic                out_valid_q;
  logic signed [19:0]  offset_q;
  logic                taken_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  tzd_step u_step (
    .state_i (state_q),
    .ch_i    (ch_q),
    .last_i  (last_q),
    .upd_o   (upd),
    .next_o  (state_d),
    .fin_o   (fin),
    .taken_o (taken)
  );

  tzd_offset u_offset (
    .state_i     (upd),
    .tz_offset_o (offset_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tzd_pkg::StateClear;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin) begin
      offset_q <= offset_d;
      taken_q  <= taken;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tz_offset_o  = offset_q;
  assign char_taken_o = taken_q;

  // hold the input only behind a stalled result
  `TZD_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked result")
  // a finished parse leaves a result and a cleared parse state
  `TZD_ASSERT_NEXT(a_fin_result, clk_i, rst_ni, adv && fin, out_valid_o && (state_q.phase == tzd_pkg::PH_SKIP), "finished parse lost or state not cleared")
  // letter phase always holds at least one letter
  `TZD_ASSERT_NOW(a_letters_present, clk_i, rst_ni, state_q.phase == tzd_pkg::PH_LETTERS, state_q.letter_count != 3'd0, "letter phase with no letters")

endmodule

`default_nettype wire
